/* hdl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue: entry and walk
// records handed between cells, order modes, actions and status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int KEY_W  = 32;
    localparam int TAG_W  = 16;
    localparam int FILL_W = 5;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [TAG_W-1:0]  tag_t;
    typedef logic [FILL_W-1:0] fill_t;
    typedef logic [1:0]        mode_t;
    typedef logic [1:0]        status_t;

    localparam mode_t MODE_STACK = 2'd0;
    localparam mode_t MODE_MAX   = 2'd1;
    localparam mode_t MODE_MIN   = 2'd2;

    localparam logic ACTION_PUSH = 1'b0;
    localparam logic ACTION_POP  = 1'b1;

    localparam status_t STATUS_DONE  = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic occ;
        key_t key;
        tag_t tag;
    } entry_t;

    typedef struct packed {
        logic v;
        logic search;
        key_t key;
        tag_t tag;
    } wave_t;

endpackage

/* hdl/spq_if.sv */
// ----------------------------------------------------------------------------
// spq interfaces
// Valid/ready channels for the request, response and mode write beats.
// ----------------------------------------------------------------------------
interface spq_req_if;
    logic          valid;
    logic          ready;
    logic          action;
    spq_pkg::key_t key;
    spq_pkg::tag_t tag;

    modport source (output valid, action, key, tag, input ready);
    modport sink   (input valid, action, key, tag, output ready);
endinterface

interface spq_rsp_if;
    logic             valid;
    logic             ready;
    spq_pkg::status_t status;
    spq_pkg::key_t    out_key;
    spq_pkg::tag_t    out_tag;
    spq_pkg::fill_t   fill;

    modport source (output valid, status, out_key, out_tag, fill, input ready);
    modport sink   (input valid, status, out_key, out_tag, fill, output ready);
endinterface

interface spq_cfg_if;
    logic           valid;
    logic           ready;
    spq_pkg::mode_t order_mode;

    modport source (output valid, order_mode, input ready);
    modport sink   (input valid, order_mode, output ready);
endinterface

/* hdl/sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded ordered store of (key, tag) entries built as a row of cells.
// ----------------------------------------------------------------------------
// One request beat is handled at a time and each gives one response beat in
// the cycle after it is taken. On a pop every cell loads its right neighbor
// at once. On a push the new entry walks down the row one cell per cycle, is
// dropped into its place and pushes the entries behind it one cell on, ending
// at the first empty cell. Pops on an empty store and pushes on a full store
// leave the store as it is. The mode register is written from its own
// channel, which is always ready, and must only change while idle.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    spq_cfg_if.sink   cfg,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {ST_IDLE, ST_WALK} state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] walk_reg, walk_next;
    wave_t         wave0_reg, wave0_next;
    mode_t         mode_reg, mode_next;
    logic          out_v_reg, out_v_next;
    status_t       out_status_reg, out_status_next;
    key_t          out_key_reg, out_key_next;
    tag_t          out_tag_reg, out_tag_next;
    fill_t         out_fill_reg, out_fill_next;

    entry_t        cells [DEPTH];
    entry_t        nxt_arr [DEPTH];
    wave_t         waves [DEPTH+1];
    logic          accept;
    logic          take;
    logic          is_pop;
    logic          empty;
    logic          full;
    logic          shift_left;
    logic [CW+4:0] fill_wide;

    assign accept     = req.valid && req.ready;
    assign take       = rsp.valid && rsp.ready;
    assign is_pop     = (req.action == ACTION_POP);
    assign empty      = (count_reg == '0);
    assign full       = (count_reg == CW'(DEPTH));
    assign shift_left = accept && is_pop && !empty;
    assign waves[0]   = wave0_reg;

    assign req.ready  = (state_reg == ST_IDLE) && (!out_v_reg || rsp.ready);
    assign cfg.ready  = 1'b1;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            if (gi == DEPTH - 1)
            begin : g_tail
                assign nxt_arr[gi] = '0;
            end
            else
            begin : g_mid
                assign nxt_arr[gi] = cells[gi+1];
            end

            spq_cell #(
                .FIRST (gi == 0)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .mode       (mode_reg),
                .shift_left (shift_left),
                .nxt        (nxt_arr[gi]),
                .own        (cells[gi]),
                .wave_in    (waves[gi]),
                .wave_out   (waves[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        walk_next       = walk_reg;
        wave0_next      = '0;
        mode_next       = mode_reg;
        out_v_next      = out_v_reg;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        out_tag_next    = out_tag_reg;

        if (cfg.valid)
        begin
            mode_next = cfg.order_mode;
        end

        if (take)
        begin
            out_v_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_v_next      = 1'b1;
                    out_status_next = STATUS_DONE;
                    out_key_next    = '0;
                    out_tag_next    = '0;
                    if (is_pop)
                    begin
                        if (empty)
                        begin
                            out_status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            out_key_next = cells[0].key;
                            out_tag_next = cells[0].tag;
                            count_next   = count_reg - CW'(1);
                        end
                    end
                    else if (full)
                    begin
                        out_status_next = STATUS_FULL;
                    end
                    else
                    begin
                        wave0_next = '{v: 1'b1, search: 1'b1, key: req.key, tag: req.tag};
                        count_next = count_reg + CW'(1);
                        walk_next  = count_reg;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                if (walk_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    walk_next = walk_reg - CW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign fill_wide     = {5'b0, count_next};
    assign out_fill_next = accept ? fill_wide[4:0] : out_fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            walk_reg       <= '0;
            wave0_reg      <= '0;
            mode_reg       <= MODE_STACK;
            out_v_reg      <= 1'b0;
            out_status_reg <= STATUS_DONE;
            out_key_reg    <= '0;
            out_tag_reg    <= '0;
            out_fill_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            walk_reg       <= walk_next;
            wave0_reg      <= wave0_next;
            mode_reg       <= mode_next;
            out_v_reg      <= out_v_next;
            out_status_reg <= out_status_next;
            out_key_reg    <= out_key_next;
            out_tag_reg    <= out_tag_next;
            out_fill_reg   <= out_fill_next;
        end
    end

    assign rsp.valid   = out_v_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.out_key = out_key_reg;
    assign rsp.out_tag = out_tag_reg;
    assign rsp.fill    = out_fill_reg;

endmodule

/* hdl/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the queue. Holds an entry, takes part in the shift toward the
// front on a pop, and handles the insert walk passing through.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter bit FIRST = 1'b0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  spq_pkg::mode_t  mode,
    input  logic            shift_left,
    input  spq_pkg::entry_t nxt,
    output spq_pkg::entry_t own,
    input  spq_pkg::wave_t  wave_in,
    output spq_pkg::wave_t  wave_out
);
    import spq_pkg::*;

    entry_t ent_reg, ent_next;
    wave_t  wave_reg, wave_next;
    logic   want_max;
    logic   ordered;
    logic   better;
    logic   worse;
    logic   pass;

    assign ordered  = (mode == MODE_MAX) || (mode == MODE_MIN);
    assign want_max = (mode == MODE_MAX);
    assign better   = want_max ? (ent_reg.key > wave_in.key) : (ent_reg.key < wave_in.key);
    assign worse    = want_max ? (ent_reg.key < wave_in.key) : (ent_reg.key > wave_in.key);
    // in order modes the head lets the new entry by unless its own is strictly worse
    assign pass     = ordered && (FIRST ? !worse : better);

    always_comb
    begin
        ent_next  = ent_reg;
        wave_next = '0;
        if (shift_left)
        begin
            ent_next = nxt;
        end
        else if (wave_in.v)
        begin
            if (!ent_reg.occ)
            begin
                ent_next = '{occ: 1'b1, key: wave_in.key, tag: wave_in.tag};
            end
            else if (wave_in.search && pass)
            begin
                wave_next = wave_in;
            end
            else
            begin
                ent_next  = '{occ: 1'b1, key: wave_in.key, tag: wave_in.tag};
                wave_next = '{v: 1'b1, search: 1'b0, key: ent_reg.key, tag: ent_reg.tag};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg  <= '0;
            wave_reg <= '0;
        end
        else
        begin
            ent_reg  <= ent_next;
            wave_reg <= wave_next;
        end
    end

    assign own      = ent_reg;
    assign wave_out = wave_reg;

endmodule

/* hdl/spq_checker.sv */
// ----------------------------------------------------------------------------
// spq_assertions
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_assertions #(
    parameter int DEPTH = 16
) (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input spq_pkg::status_t status,
    input spq_pkg::key_t    out_key,
    input spq_pkg::tag_t    out_tag,
    input spq_pkg::fill_t   fill
);
    import spq_pkg::*;

    localparam fill_t FULL_FILL = FILL_W'(DEPTH);

    a_beat_gives_response: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted request beat gave no response beat");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_EMPTY |->
            out_key == '0 && out_tag == '0 && fill == '0)
        else $error("empty pop response is not all zero");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_FULL |->
            out_key == '0 && out_tag == '0 && fill == FULL_FILL)
        else $error("full push response is wrong");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (DEPTH > 31) || (32'(fill) <= 32'(DEPTH)))
        else $error("fill beyond depth");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(fill))
        else $error("stalled response beat changed");

endmodule

bind sorted_priority_queue spq_assertions #(
    .DEPTH (DEPTH)
) u_spq_assertions (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (rsp.status),
    .out_key   (rsp.out_key),
    .out_tag   (rsp.out_tag),
    .fill      (rsp.fill)
);
